@@ sv/twsbm_pkg.sv @@
// ----------------------------------------------------------------------------
// twsbm_pkg
// Shared types and constants for the two-wire sensor bus master.
// ----------------------------------------------------------------------------
package twsbm_pkg;

   localparam int unsigned CMD_W     = 8;
   localparam int unsigned TIMEOUT_W = 24;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [CMD_W-1:0]     TEMP_CMD_RST    = 8'd3;
   localparam logic [CMD_W-1:0]     HUM_CMD_RST     = 8'd5;
   localparam logic [CMD_W-1:0]     SOFT_CMD_RST    = 8'd30;
   localparam logic [TIMEOUT_W-1:0] WAIT_TIMEOUT_RST = 24'd160000;

   // start pattern, tick i in bit i
   localparam logic [7:0] START_CLK = 8'h6C;
   localparam logic [7:0] START_DAT = 8'hC7;

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_SOFT_RST = 2'd1,
      OP_TEMP     = 2'd2,
      OP_HUMIDITY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_TEMP_CMD     = 2'd0,
      CSR_HUM_CMD      = 2'd1,
      CSR_SOFT_CMD     = 2'd2,
      CSR_WAIT_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_PRE   = 4'd1,
      PH_RST_PULSE = 4'd2,
      PH_START     = 4'd3,
      PH_WBIT      = 4'd4,
      PH_WACK      = 4'd5,
      PH_WAIT      = 4'd6,
      PH_RPRE      = 4'd7,
      PH_RBIT      = 4'd8,
      PH_RACK      = 4'd9
   } phase_type;

   typedef struct packed {
      logic [CMD_W-1:0]     temp_cmd;
      logic [CMD_W-1:0]     hum_cmd;
      logic [CMD_W-1:0]     soft_cmd;
      logic [TIMEOUT_W-1:0] wait_timeout;
   } cfg_type;

   typedef struct packed {
      logic        clock_level;
      logic        data_drive;
      logic        data_level;
      logic        busy;
      logic        done;
      logic [15:0] measurement;
      logic [7:0]  crc_byte;
      logic [1:0]  error_count;
   } res_type;

endpackage

@@ sv/twsbm_csr.sv @@
// ----------------------------------------------------------------------------
// twsbm_csr
// Configuration register file: command bytes and wait timeout.
// ----------------------------------------------------------------------------
module twsbm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [twsbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twsbm_pkg::TIMEOUT_W-1:0]     csr_data,
   output twsbm_pkg::cfg_type                  cfg
);

   twsbm_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (twsbm_pkg::csr_index_type'(csr_index))
            twsbm_pkg::CSR_TEMP_CMD:     cfg_in.temp_cmd = csr_data[twsbm_pkg::CMD_W-1:0];
            twsbm_pkg::CSR_HUM_CMD:      cfg_in.hum_cmd  = csr_data[twsbm_pkg::CMD_W-1:0];
            twsbm_pkg::CSR_SOFT_CMD:     cfg_in.soft_cmd = csr_data[twsbm_pkg::CMD_W-1:0];
            twsbm_pkg::CSR_WAIT_TIMEOUT: cfg_in.wait_timeout = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_cmd     <= twsbm_pkg::TEMP_CMD_RST;
         cfg_ff.hum_cmd      <= twsbm_pkg::HUM_CMD_RST;
         cfg_ff.soft_cmd     <= twsbm_pkg::SOFT_CMD_RST;
         cfg_ff.wait_timeout <= twsbm_pkg::WAIT_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/twsbm_seq.sv @@
// ----------------------------------------------------------------------------
// twsbm_seq
// Bus sequencer: advances one phase tick per step and forms the pin drive.
// ----------------------------------------------------------------------------
module twsbm_seq #(
   parameter int unsigned RESET_PULSES  = 9,
   parameter int unsigned TIMEOUT_WIDTH = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          op,
   input  logic                ds,
   input  twsbm_pkg::cfg_type  cfg,
   output twsbm_pkg::res_type  res
);

   localparam int unsigned LIM_W =
      (TIMEOUT_WIDTH > twsbm_pkg::TIMEOUT_W) ? TIMEOUT_WIDTH : twsbm_pkg::TIMEOUT_W;
   localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'({TIMEOUT_WIDTH{1'b1}});
   localparam logic [4:0] PULSE_LAST = 5'(RESET_PULSES);

   twsbm_pkg::phase_type       phase_ff, phase_in;
   logic [2:0]                 ptick_ff, ptick_in;
   logic [3:0]                 bit_ff, bit_in;
   logic [1:0]                 byte_ff, byte_in;
   logic [7:0]                 shift_ff, shift_in;
   logic [TIMEOUT_WIDTH-1:0]   wcount_ff, wcount_in;
   logic [1:0]                 err_ff, err_in;
   logic [15:0]                word_ff, word_in;
   logic [7:0]                 crc_ff, crc_in;
   logic [1:0]                 cmd_ff, cmd_in;

   logic [LIM_W-1:0]           tmo_wide;
   logic [TIMEOUT_WIDTH-1:0]   wait_limit;
   logic [TIMEOUT_WIDTH:0]     wcount_inc;
   logic                       clk_v, drv_v, lvl_v, done_v, busy_v;

   assign tmo_wide   = LIM_W'(cfg.wait_timeout);
   assign wait_limit = (tmo_wide > LIM_MAX) ? LIM_MAX[TIMEOUT_WIDTH-1:0]
                                            : tmo_wide[TIMEOUT_WIDTH-1:0];
   assign wcount_inc = {1'b0, wcount_ff} + {{TIMEOUT_WIDTH{1'b0}}, 1'b1};

   always_comb begin
      phase_in  = phase_ff;
      ptick_in  = ptick_ff;
      bit_in    = bit_ff;
      byte_in   = byte_ff;
      shift_in  = shift_ff;
      wcount_in = wcount_ff;
      err_in    = err_ff;
      word_in   = word_ff;
      crc_in    = crc_ff;
      cmd_in    = cmd_ff;
      clk_v     = 1'b0;
      drv_v     = 1'b0;
      lvl_v     = 1'b0;
      done_v    = 1'b0;
      busy_v    = 1'b0;

      if (phase_ff == twsbm_pkg::PH_IDLE && op != twsbm_pkg::OP_TICK) begin
         cmd_in   = op;
         err_in   = '0;
         word_in  = '0;
         crc_in   = '0;
         byte_in  = '0;
         bit_in   = '0;
         ptick_in = '0;
         phase_in = (op == twsbm_pkg::OP_SOFT_RST) ? twsbm_pkg::PH_RST_PRE
                                                   : twsbm_pkg::PH_START;
      end

      busy_v = (phase_in != twsbm_pkg::PH_IDLE);

      unique case (phase_in)
         twsbm_pkg::PH_IDLE: begin
         end
         twsbm_pkg::PH_RST_PRE: begin
            drv_v = 1'b1;
            lvl_v = 1'b1;
            if (ptick_in == 3'd1) begin
               ptick_in = '0;
               bit_in   = '0;
               phase_in = twsbm_pkg::PH_RST_PULSE;
            end else begin
               ptick_in = ptick_in + 3'd1;
            end
         end
         twsbm_pkg::PH_RST_PULSE: begin
            drv_v = 1'b1;
            lvl_v = 1'b1;
            if (ptick_in == '0) begin
               clk_v    = 1'b1;
               ptick_in = 3'd1;
            end else begin
               ptick_in = '0;
               if ({1'b0, bit_in} + 5'd1 >= PULSE_LAST) begin
                  bit_in   = '0;
                  phase_in = twsbm_pkg::PH_START;
               end else begin
                  bit_in = bit_in + 4'd1;
               end
            end
         end
         twsbm_pkg::PH_START: begin
            clk_v = twsbm_pkg::START_CLK[ptick_in];
            drv_v = 1'b1;
            lvl_v = twsbm_pkg::START_DAT[ptick_in];
            if (ptick_in == 3'd7) begin
               ptick_in = '0;
               bit_in   = '0;
               phase_in = twsbm_pkg::PH_WBIT;
               unique case (twsbm_pkg::op_type'(cmd_in))
                  twsbm_pkg::OP_SOFT_RST: shift_in = cfg.soft_cmd;
                  twsbm_pkg::OP_TEMP:     shift_in = cfg.temp_cmd;
                  default:                shift_in = cfg.hum_cmd;
               endcase
            end else begin
               ptick_in = ptick_in + 3'd1;
            end
         end
         twsbm_pkg::PH_WBIT: begin
            clk_v = (ptick_in == 3'd1);
            drv_v = 1'b1;
            lvl_v = shift_in[7];
            if (ptick_in == 3'd2) begin
               ptick_in = '0;
               shift_in = {shift_in[6:0], 1'b0};
               if (bit_in == 4'd7) begin
                  bit_in   = '0;
                  phase_in = twsbm_pkg::PH_WACK;
               end else begin
                  bit_in = bit_in + 4'd1;
               end
            end else begin
               ptick_in = ptick_in + 3'd1;
            end
         end
         twsbm_pkg::PH_WACK: begin
            clk_v = (ptick_in == 3'd1);
            if (ptick_in == 3'd1 && ds && err_in != 2'd2) begin
               err_in = err_in + 2'd1;
            end
            if (ptick_in == 3'd2) begin
               ptick_in = '0;
               if (cmd_in == twsbm_pkg::OP_SOFT_RST) begin
                  done_v   = 1'b1;
                  phase_in = twsbm_pkg::PH_IDLE;
               end else begin
                  wcount_in = '0;
                  phase_in  = twsbm_pkg::PH_WAIT;
               end
            end else begin
               ptick_in = ptick_in + 3'd1;
            end
         end
         twsbm_pkg::PH_WAIT: begin
            if (!ds) begin
               phase_in = twsbm_pkg::PH_RPRE;
            end else begin
               wcount_in = wcount_inc[TIMEOUT_WIDTH-1:0];
               if (wcount_inc >= {1'b0, wait_limit}) begin
                  if (err_in != 2'd2) begin
                     err_in = err_in + 2'd1;
                  end
                  phase_in = twsbm_pkg::PH_RPRE;
               end
            end
         end
         twsbm_pkg::PH_RPRE: begin
            drv_v    = 1'b1;
            lvl_v    = 1'b1;
            ptick_in = '0;
            bit_in   = '0;
            shift_in = '0;
            phase_in = twsbm_pkg::PH_RBIT;
         end
         twsbm_pkg::PH_RBIT: begin
            if (ptick_in == '0) begin
               clk_v    = 1'b1;
               shift_in = {shift_in[6:0], ds};
               ptick_in = 3'd1;
            end else begin
               ptick_in = '0;
               if (bit_in == 4'd7) begin
                  bit_in   = '0;
                  phase_in = twsbm_pkg::PH_RACK;
               end else begin
                  bit_in = bit_in + 4'd1;
               end
            end
         end
         twsbm_pkg::PH_RACK: begin
            drv_v = 1'b1;
            if (ptick_in < 3'd2) begin
               clk_v    = (ptick_in == '0);
               lvl_v    = (byte_in == 2'd2);
               ptick_in = ptick_in + 3'd1;
            end else begin
               lvl_v    = 1'b1;
               ptick_in = '0;
               priority case (byte_in)
                  2'd0: begin
                     word_in  = {shift_in, 8'h00};
                     byte_in  = 2'd1;
                     phase_in = twsbm_pkg::PH_RPRE;
                  end
                  2'd1: begin
                     word_in  = {word_in[15:8], shift_in};
                     byte_in  = 2'd2;
                     phase_in = twsbm_pkg::PH_RPRE;
                  end
                  default: begin
                     crc_in   = shift_in;
                     done_v   = 1'b1;
                     phase_in = twsbm_pkg::PH_IDLE;
                  end
               endcase
            end
         end
         default: begin
            phase_in = twsbm_pkg::PH_IDLE;
         end
      endcase

      res.clock_level = clk_v;
      res.data_drive  = drv_v;
      res.data_level  = drv_v & lvl_v;
      res.busy        = busy_v;
      res.done        = done_v;
      res.measurement = done_v ? word_in : 16'h0000;
      res.crc_byte    = done_v ? crc_in : 8'h00;
      res.error_count = done_v ? err_in : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= twsbm_pkg::PH_IDLE;
         ptick_ff  <= '0;
         bit_ff    <= '0;
         byte_ff   <= '0;
         shift_ff  <= '0;
         wcount_ff <= '0;
         err_ff    <= '0;
         word_ff   <= '0;
         crc_ff    <= '0;
         cmd_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         ptick_ff  <= ptick_in;
         bit_ff    <= bit_in;
         byte_ff   <= byte_in;
         shift_ff  <= shift_in;
         wcount_ff <= wcount_in;
         err_ff    <= err_in;
         word_ff   <= word_in;
         crc_ff    <= crc_in;
         cmd_ff    <= cmd_in;
      end
   end

endmodule

@@ sv/two_wire_sensor_bus_master_unit.sv @@
// ----------------------------------------------------------------------------
// two_wire_sensor_bus_master_unit
// Bit-level master for a two-wire humidity/temperature sensor bus.
// ----------------------------------------------------------------------------
// each req transaction is one bus phase tick: tuser carries the command
// (plain tick, soft reset, temperature, humidity) and tdata the sampled
// data pin. every req transaction gives exactly one rsp transaction with the
// clock level and data drive for that tick; tlast marks the tick that ends
// a command sequence, and then tdata also carries the measurement, the
// checksum byte and the error count.
// a req transaction lands in an input register and its rsp is registered in
// an output register when the sequencer steps on it. one transaction per
// cycle is sustained unless the receiver stalls; the sequencer state advances
// once per tick through a single step of logic between the two registers.
// when the receiver stalls, the output register holds its rsp, the input
// register holds the next tick and req_tready drops only once both are full.
// reset returns the sequencer to idle, empties both registers and loads the
// register defaults (commands 3, 5, 30; wait timeout 160000 ticks).
// the csr channel is always ready and takes one register write per cycle.
// ----------------------------------------------------------------------------
module two_wire_sensor_bus_master_unit #(
   parameter int unsigned RESET_PULSES  = 9,
   parameter int unsigned TIMEOUT_WIDTH = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [twsbm_pkg::REQ_DATA_W-1:0]        req_tdata,   // data_sample
   input  logic [1:0]                              req_tuser,   // op
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // clock_level, data_drive, data_level, busy_res, measurement, crc_byte,
   // error_count
   output logic [twsbm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                    rsp_tlast,   // done_res
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [twsbm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [twsbm_pkg::TIMEOUT_W-1:0]         csr_data
);

   twsbm_pkg::cfg_type cfg;
   twsbm_pkg::res_type res;

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff;
   logic        in_ds_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [twsbm_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        advance;
   logic        step;
   logic        req_take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   twsbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   twsbm_seq #(
      .RESET_PULSES  (RESET_PULSES),
      .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .op    (in_op_ff),
      .ds    (in_ds_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff <= req_tuser;
         in_ds_ff <= req_tdata[0];
      end
      if (step) begin
         rsp_data_ff <= {2'b00, res.error_count, res.crc_byte, res.measurement,
                         res.busy, res.data_level, res.data_drive, res.clock_level};
         rsp_last_ff <= res.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
